// ===== rtl/core/lvp_pkg.sv =====
`default_nettype none
package lvp_pkg;

	localparam int MAX_LEN   = 1024;
	localparam int LEN_W     = 11;
	localparam int POS_W     = $clog2(MAX_LEN + 1);
	localparam int SP_W      = $clog2(MAX_LEN + 2);
	localparam int ADDR_W    = $clog2(MAX_LEN);
	localparam int RAM_DEPTH = 2 ** ADDR_W;

	localparam logic [7:0] OPEN_CODE = 8'h28;

	typedef struct packed {
		logic [7:0] char_code;
		logic       is_last;
	} char_beat_t;

	typedef struct packed {
		logic [LEN_W-1:0] max_length;
		logic             overflow;
	} res_beat_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [POS_W-1:0]  wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic      valid;
		res_beat_t beat;
	} scan_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/lvp_stack_ram.sv =====
`default_nettype none
module lvp_stack_ram (
	input  wire               clk,
	input  lvp_pkg::ram_req_t req,
	output logic [lvp_pkg::POS_W-1:0] rd_data
);
	import lvp_pkg::*;

	logic [POS_W-1:0] mem [RAM_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// write-first on a same-address collision
	always_ff @(posedge clk) begin
		if (req.we && (req.waddr == req.raddr)) begin
			rd_data <= req.wdata;
		end else begin
			rd_data <= mem[req.raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/lvp_scan.sv =====
`default_nettype none
module lvp_scan (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          take,
	input  lvp_pkg::char_beat_t          beat,
	input  wire  [lvp_pkg::POS_W-1:0]    rd_data,
	output lvp_pkg::ram_req_t            ram_req,
	output lvp_pkg::scan_res_t           res
);
	import lvp_pkg::*;

	// top and second entry live in flops, the rest of the stack in ram
	logic [POS_W-1:0] top_q, top_d;
	logic [POS_W-1:0] under_q, under_d;
	logic [SP_W-1:0]  sp_q, sp_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [POS_W-1:0] best_q, best_d;
	logic             ovf_q, ovf_d;

	logic [POS_W-1:0]       here;
	logic [POS_W-1:0]       len;
	logic [SP_W-1:0]        sp_wr;
	logic [SP_W-1:0]        sp_rd;
	logic [POS_W+LEN_W-1:0] best_wide;

	assign here  = pos_q + POS_W'(1);
	assign len   = (here >= under_q) ? (here - under_q) : '0;
	assign sp_wr = sp_q - SP_W'(2);
	assign sp_rd = sp_d - SP_W'(3);

	always_comb begin
		top_d      = top_q;
		under_d    = under_q;
		sp_d       = sp_q;
		pos_d      = pos_q;
		best_d     = best_q;
		ovf_d      = ovf_q;
		ram_req.we = 1'b0;
		if (take) begin
			if (pos_q >= POS_W'(MAX_LEN)) begin
				ovf_d = 1'b1;
			end else if (beat.char_code == OPEN_CODE) begin
				pos_d = here;
				if (sp_q < SP_W'(MAX_LEN + 1)) begin
					top_d      = here;
					under_d    = top_q;
					sp_d       = sp_q + SP_W'(1);
					ram_req.we = (sp_q >= SP_W'(2));
				end
			end else begin
				pos_d = here;
				if (sp_q <= SP_W'(1)) begin
					// stack emptied: this position is the new base
					top_d = here;
					sp_d  = SP_W'(1);
				end else begin
					top_d   = under_q;
					under_d = rd_data;
					sp_d    = sp_q - SP_W'(1);
					if (len > best_q) begin
						best_d = len;
					end
				end
			end
		end
		best_wide      = {LEN_W'(0), best_d};
		res.valid      = take && beat.is_last;
		res.beat.max_length = best_wide[LEN_W-1:0];
		res.beat.overflow   = ovf_d;
		if (take && beat.is_last) begin
			top_d  = '0;
			sp_d   = SP_W'(1);
			pos_d  = '0;
			best_d = '0;
			ovf_d  = 1'b0;
		end
		// the entry pushed down lands where the next prefetch reads, unless the push ends the string
		ram_req.waddr = sp_wr[ADDR_W-1:0];
		ram_req.wdata = under_q;
		ram_req.raddr = sp_rd[ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q  <= '0;
			sp_q   <= SP_W'(1);
			pos_q  <= '0;
			best_q <= '0;
			ovf_q  <= 1'b0;
		end else begin
			top_q  <= top_d;
			sp_q   <= sp_d;
			pos_q  <= pos_d;
			best_q <= best_d;
			ovf_q  <= ovf_d;
		end
	end

	always_ff @(posedge clk) begin
		under_q <= under_d;
	end

endmodule
`default_nettype wire

// ===== rtl/core/longest_valid_parentheses.sv =====
// result: the result beat is valid in the cycle after the beat of the last character
// throughput: one character per cycle while the result slot is free or draining, set
//   by the top-of-stack flops and a registered ram prefetch of the third entry
// reset: arst_n asynchronous, active low; restores a stack holding only the base
//   of minus one; the ram needs no clearing pass since only entries written
//   during the current string are ever used
`default_nettype none
module longest_valid_parentheses (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  char_valid,
	output logic                 char_ready,
	input  lvp_pkg::char_beat_t  char_data,
	output logic                 res_valid,
	input  wire                  res_ready,
	output lvp_pkg::res_beat_t   res_data
);
	import lvp_pkg::*;

	logic      take;
	ram_req_t  ram_req;
	logic [POS_W-1:0] rd_data;
	scan_res_t scan_res;

	logic      res_valid_q;
	res_beat_t res_q;

	// a character beat is taken whenever the result slot is free or draining
	assign char_ready = !res_valid_q || res_ready;
	assign take       = char_valid && char_ready;

	// stack body below the two cached entries
	lvp_stack_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	// per-character push/pop and running maximum
	lvp_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.beat    (char_data),
		.rd_data (rd_data),
		.ram_req (ram_req),
		.res     (scan_res)
	);

	// output register: holds the result beat until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (scan_res.valid) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_res.valid) begin
			res_q <= scan_res.beat;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule
`default_nettype wire

// ===== rtl/core/lvp_checker.sv =====
`default_nettype none
module lvp_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  char_valid,
	input wire                  char_ready,
	input lvp_pkg::char_beat_t  char_data,
	input wire                  res_valid,
	input wire                  res_ready,
	input lvp_pkg::res_beat_t   res_data
);
	import lvp_pkg::*;

	// a stalled result beat stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result beat dropped or changed while stalled");

	// balanced substrings always have even length
	a_even: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !res_data.max_length[0])
		else $error("odd max_length");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (MAX_LEN > 2047) || (res_data.max_length <= LEN_W'(MAX_LEN)))
		else $error("max_length beyond string limit");

	// input stalls only behind a full, stalled result slot
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!char_ready |-> res_valid && !res_ready)
		else $error("input stalled without cause");

	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_ready && char_data.is_last |=> res_valid)
		else $error("last character gave no result beat");

endmodule

bind longest_valid_parentheses lvp_checker u_chk (.*);
`default_nettype wire

// ===== tb/lvp_checker.sv =====
`timescale 1ns / 1ps
module tb_lvp_checker (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 char_valid,
	input  wire                 char_ready,
	input  lvp_pkg::char_beat_t char_data,
	input  wire                 res_valid,
	input  wire                 res_ready,
	input  lvp_pkg::res_beat_t  res_data,
	output int                  mismatches,
	output int                  pending
);
	import lvp_pkg::*;

	// scan state, positions kept offset by one so the base of minus one is zero
	logic [POS_W-1:0] pos_stack [0:MAX_LEN];
	logic [SP_W-1:0]  depth;
	logic [POS_W-1:0] next_pos;
	logic [LEN_W-1:0] best_len;
	logic             over_seen;

	res_beat_t length_queue [$];
	res_beat_t want;

	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic clear_scan();
		pos_stack[0] = '0;
		depth        = SP_W'(1);
		next_pos     = '0;
		best_len     = '0;
		over_seen    = 1'b0;
	endtask

	task automatic scan_char(input logic [7:0] code);
		logic [POS_W-1:0] here;
		logic [POS_W-1:0] top;
		logic [LEN_W-1:0] span;
		// past the length limit only the overflow flag moves
		if (next_pos >= MAX_LEN) begin
			over_seen = 1'b1;
			return;
		end
		here = next_pos + 1'b1;
		if (code == OPEN_CODE) begin
			if (depth < MAX_LEN + 1) begin
				pos_stack[depth] = here;
				depth++;
			end
		end else begin
			if (depth > 0)
				depth--;
			if (depth == 0) begin
				pos_stack[0] = here;
				depth = SP_W'(1);
			end else begin
				top  = pos_stack[depth - 1'b1];
				span = (here >= top) ? LEN_W'(here - top) : '0;
				if (span > best_len)
					best_len = span;
			end
		end
		next_pos++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			length_queue.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (length_queue.size() == 0) begin
					report_mismatch($sformatf("result beat with nothing expected: len %0d ovf %0b",
						res_data.max_length, res_data.overflow));
				end else begin
					want = length_queue.pop_front();
					if (res_data.max_length !== want.max_length)
						report_mismatch($sformatf("max_length got %0d want %0d",
							res_data.max_length, want.max_length));
					if (res_data.overflow !== want.overflow)
						report_mismatch($sformatf("overflow got %0b want %0b",
							res_data.overflow, want.overflow));
				end
			end
			if (char_valid && char_ready) begin
				scan_char(char_data.char_code);
				if (char_data.is_last) begin
					length_queue.push_back(res_beat_t'{max_length: best_len,
						overflow: over_seen});
					clear_scan();
				end
			end
			pending <= length_queue.size();
		end
	end

endmodule

// ===== tb/tb_longest_valid_parentheses.sv =====
`timescale 1ns / 1ps
module tb_longest_valid_parentheses;
	import lvp_pkg::*;

	// the usual closing character; any byte other than the opener also closes
	localparam logic [7:0] CLOSE_CODE    = 8'h29;
	// character budget of the short random strings, split evenly over the three idling phases
	localparam int         SHORT_ITEMS   = 900;
	// result comes in the cycle after the last character, so a short drain is plenty
	localparam int         SETTLE_CYCLES = 20;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       char_valid = 1'b0;
	logic       char_ready;
	char_beat_t char_data  = '0;
	logic       res_valid;
	logic       res_ready  = 1'b0;
	res_beat_t  res_data;

	// idle chances in percent, changed per phase
	int send_idle  = 0;
	int recv_stall = 0;
	int sent       = 0;
	int mismatches;
	int pending;

	// characters of the string being built
	logic [7:0] text [$];

	always #5 clk = ~clk;

	longest_valid_parentheses DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_data  (char_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data)
	);

	tb_lvp_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_data  (char_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// receiver stalls each cycle with the phase's chance, independent of res_valid
	always @(posedge clk) begin
		res_ready <= ($urandom_range(0, 99) >= recv_stall);
	end

	// one character beat; the random gap comes first so valid never drops
	// while a beat is waiting
	task automatic send_char(input logic [7:0] code, input logic last);
		while ($urandom_range(0, 99) < send_idle) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_data  <= '{char_code: code, is_last: last};
		@(posedge clk);
		while (!char_ready)
			@(posedge clk);
		sent++;
	endtask

	// send the built string, flagging its final character
	task automatic send_text();
		foreach (text[i])
			send_char(text[i], i == text.size() - 1);
		text.delete();
	endtask

	task automatic send_literal(input string s);
		for (int i = 0; i < s.len(); i++)
			text.push_back(s[i]);
		send_text();
	endtask

	// closing byte: mostly ')', sometimes any other non-opening byte
	function automatic logic [7:0] close_char();
		logic [7:0] code;
		if ($urandom_range(0, 4) != 0)
			return CLOSE_CODE;
		do
			code = 8'($urandom_range(0, 255));
		while (code == OPEN_CODE);
		return code;
	endfunction

	// random walk that always closes what it opened, so nesting and
	// concatenation both show up
	task automatic build_balanced(input int pairs);
		int open_left;
		int level;
		open_left = pairs;
		level     = 0;
		while (open_left > 0 || level > 0) begin
			if (open_left > 0 && (level == 0 || $urandom_range(0, 1))) begin
				text.push_back(OPEN_CODE);
				open_left--;
				level++;
			end else begin
				text.push_back(close_char());
				level--;
			end
		end
	endtask

	task automatic send_random_string();
		int kind;
		int len;
		int flips;
		kind = $urandom_range(0, 99);
		// mostly short strings, now and then a longer one
		len  = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
		if (kind < 55) begin
			// well-formed core, sometimes broken or extended
			build_balanced((len + 1) / 2);
			if ($urandom_range(0, 2) == 0) begin
				flips = $urandom_range(1, 3);
				repeat (flips)
					text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
			end
			if ($urandom_range(0, 3) == 0)
				build_balanced($urandom_range(1, 10));
		end else if (kind < 85) begin
			// loose mix of openers and closers
			repeat (len)
				text.push_back($urandom_range(0, 1) ? OPEN_CODE : close_char());
		end else begin
			// raw byte noise
			repeat (len)
				text.push_back(8'($urandom_range(0, 255)));
		end
		send_text();
	endtask

	task automatic send_short_strings(input int count);
		int stop;
		stop = sent + count;
		while (sent < stop)
			send_random_string();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// phase one: sender idles lightly, receiver stalls often
		send_idle  = 20;
		recv_stall = 57;

		// directed strings: lone closer and opener, simple pair, unmatched
		// prefix, reset of the base in the middle, nesting after a pair
		send_literal(")");
		send_literal("(");
		send_literal("()");
		send_literal("(()");
		send_literal(")()())");
		send_literal("()(())");
		// a one-bit neighbor and the extremes of the opening byte all count as closing
		send_char(OPEN_CODE, 1'b0);
		send_char(8'hA8, 1'b1);
		send_char(8'h00, 1'b0);
		send_char(OPEN_CODE, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(OPEN_CODE, 1'b1);

		send_short_strings(SHORT_ITEMS / 3);

		// phase two: roles swapped
		send_idle  = 57;
		recv_stall = 20;

		// longest possible match followed by characters past the limit:
		// length saturates at the limit and overflow is flagged
		repeat (MAX_LEN / 2)
			text.push_back(OPEN_CODE);
		repeat (MAX_LEN / 2)
			text.push_back(CLOSE_CODE);
		repeat (4)
			text.push_back(8'($urandom_range(0, 255)));
		send_text();

		send_short_strings(SHORT_ITEMS / 3);

		// phase three: full rate both ways
		send_idle  = 0;
		recv_stall = 0;
		send_short_strings(SHORT_ITEMS / 3);

		char_valid <= 1'b0;
		// let the checker register the last beat before polling its count
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog, well beyond the slowest legal run
	initial begin
		#5000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
